// ===== rtl/jos_pkg.sv =====
// Shared widths and limits for the Josephus survivor block.
`timescale 1ns / 1ps

package jos_pkg;

  localparam int unsigned MaxPeople   = 512;
  localparam int unsigned CountW      = 10;                  // people_count, survivor
  localparam int unsigned StepW       = 16;                  // step_count
  localparam int unsigned StepExtW    = StepW + 1;           // step with zero read as 2^16
  localparam int unsigned PosW        = $clog2(MaxPeople);   // 0-based position
  localparam int unsigned CircleW     = PosW + 1;            // holds MaxPeople itself
  localparam int unsigned DividendW   = StepExtW + 1;        // position + step
  localparam int unsigned BitCntW     = $clog2(DividendW);
  localparam int unsigned InTdataW    = ((CountW + StepW + 7) / 8) * 8;
  localparam int unsigned OutTdataW   = ((CountW + 7) / 8) * 8;

  localparam logic [CountW-1:0]  MaxPeopleVal = CountW'(MaxPeople);
  localparam logic [BitCntW-1:0] LastBit      = BitCntW'(DividendW - 1);

endpackage

// ===== rtl/josephus_survivor.sv =====
// Josephus survivor: iterative remainder recurrence on one shared subtractor.
//
//  channel  dir  fields (lsb first)                       handshake
//  s_axis   in   people_count[9:0] step_count[25:10]      s_axis_tvalid/tready
//  m_axis   out  survivor[9:0]                            m_axis_tvalid/tready
//
// Each item runs the bit-serial restoring remainder unit for every circle size k
// from 2 to n when n >= 2, with 18 shift/subtract steps per circle size k.
// n of 0 or 1 skips the unit. Reset is asynchronous, active low, clears control.
// s_axis_tready is high only while the sequencer is idle; a finished result waits
// in the output register and the next item is taken meanwhile.
`timescale 1ns / 1ps

module josephus_survivor
  import jos_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // people_count, step_count, zero pad
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // survivor, zero pad
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CountW-1:0]    n_q, n_d;
  logic [StepExtW-1:0]  m_q, m_d;
  logic [CircleW-1:0]   k_q, k_d;
  logic [DividendW-1:0] div_q, div_d;
  logic [PosW-1:0]      rem_q, rem_d;
  logic [BitCntW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0]    res_q, res_d;
  logic [CountW-1:0]    out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  logic [CountW-1:0]    in_n, n_sat;
  logic [StepW-1:0]     in_m;
  logic [StepExtW-1:0]  m_ext;
  logic [CircleW:0]     trial;
  logic [CircleW:0]     diff;
  logic                 fits;
  logic [PosW-1:0]      rem_next;

  assign in_n  = s_axis_tdata[CountW-1:0];
  assign in_m  = s_axis_tdata[CountW+StepW-1:CountW];
  assign n_sat = (in_n > MaxPeopleVal) ? MaxPeopleVal : in_n;
  assign m_ext = {(in_m == '0), in_m};

  // Shared unit: shift in the next dividend bit, subtract k when it fits.
  assign trial    = {1'b0, rem_q, div_q[DividendW-1]};
  assign diff     = trial - {1'b0, k_q};
  assign fits     = trial >= {1'b0, k_q};
  assign rem_next = fits ? diff[PosW-1:0] : trial[PosW-1:0];

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutTdataW-CountW){1'b0}}, out_q};

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    m_d       = m_q;
    k_d       = k_q;
    div_d     = div_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          n_d   = n_sat;
          m_d   = m_ext;
          k_d   = CircleW'(2);
          div_d = {1'b0, m_ext};
          rem_d = '0;
          cnt_d = '0;
          if (n_sat <= CountW'(1)) begin
            res_d   = n_sat;
            state_d = StFin;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        div_d = {div_q[DividendW-2:0], 1'b0};
        rem_d = rem_next;
        cnt_d = cnt_q + BitCntW'(1);
        if (cnt_q == LastBit) begin
          // Remainder for this k done: advance k and reload position + step.
          cnt_d = '0;
          rem_d = '0;
          div_d = DividendW'(rem_next) + DividendW'(m_q);
          k_d   = k_q + CircleW'(1);
          if (CountW'(k_q) == n_q) begin
            res_d   = CountW'(rem_next) + CountW'(1);
            state_d = StFin;
          end
        end
      end
      StFin: begin
        // Hold until the output register is free.
        if (!out_vld_q || m_axis_tready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    m_q   <= m_d;
    k_q   <= k_d;
    div_q <= div_d;
    rem_q <= rem_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule
